>>> rtl/core/lscm_pkg.sv
// Shared types and constants for the line sensor centroid and marks block.
package lscm_pkg;

	localparam int SENSOR_COUNT = 8;
	localparam int WEIGHT_W     = 8;
	localparam int WEIGHTS_W    = SENSOR_COUNT * WEIGHT_W;
	localparam int CNT_W        = 4;
	localparam int SUM_W        = 11;
	localparam int MAG_W        = 15;
	localparam int ERR_W        = 12;
	localparam int GAP_W        = 9;
	localparam int FIN_W        = 3;
	localparam int STEP_W       = 4;
	localparam int CFG_IDX_W    = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_THR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_HOLD = 2'd3;

	// Track status codes
	localparam logic [1:0] STATUS_DISABLED = 2'd0;
	localparam logic [1:0] STATUS_FOUND    = 2'd1;
	localparam logic [1:0] STATUS_LOST     = 2'd2;

	// Finish debounce limits
	localparam logic [FIN_W-1:0] FINISH_MAX = 3'd5;
	localparam logic [FIN_W-1:0] FINISH_ON  = 3'd3;

	typedef struct packed {
		logic [WEIGHTS_W-1:0] weights;
		logic [CNT_W-1:0]     line_thr;
		logic [7:0]           dash_thr;
		logic [7:0]           dash_hold;
	} cfg_t;

	// One classified frame waiting for the divider
	typedef struct packed {
		logic [MAG_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
		logic             neg;
		logic [1:0]       status;
		logic             dashed;
		logic             finish;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

>>> rtl/core/lscm_front.sv
// Front end: accepts frames, runs the gap and finish detectors, forms the divide job.
module lscm_front
	import lscm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    push,
	input  logic [SENSOR_COUNT-1:0] sensor_bits,
	input  logic                    enable,
	input  logic                    queue_full,
	output logic                    job_push,
	output job_t                    job
);

	logic [GAP_W-1:0]        gap_q, gap_next, gap_ceil;
	logic                    dashed_q, dashed_next;
	logic [FIN_W-1:0]        fin_q, fin_next;
	logic                    finish_next;
	logic                    accept;
	logic signed [SUM_W-1:0] sum;
	logic [CNT_W-1:0]        cnt;
	logic [SUM_W-1:0]        abs_sum;
	logic                    found;

	assign accept   = push & ~queue_full;
	assign job_push = accept;
	assign gap_ceil = {1'b0, cfg.dash_thr} + {1'b0, cfg.dash_hold};

	// Gap detector on the two middle sensors
	always_comb begin
		gap_next = gap_q;
		if (!sensor_bits[3] && !sensor_bits[4]) begin
			if (gap_q < gap_ceil) gap_next = gap_q + GAP_W'(1);
		end else if (gap_q != '0) begin
			gap_next = gap_q - GAP_W'(1);
		end
		dashed_next = dashed_q;
		if (gap_next >= {1'b0, cfg.dash_thr}) dashed_next = 1'b1;
		else if (gap_next == '0) dashed_next = 1'b0;
	end

	// Finish debounce on the six middle sensors
	always_comb begin
		fin_next = fin_q;
		if (sensor_bits[6:1] == 6'h3f) begin
			if (fin_q < FINISH_MAX) fin_next = fin_q + FIN_W'(1);
		end else if (fin_q != '0) begin
			fin_next = fin_q - FIN_W'(1);
		end
		finish_next = (fin_next >= FINISH_ON);
	end

	// Sum the weights of the active sensors and count them
	always_comb begin
		sum = '0;
		cnt = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (sensor_bits[i]) begin
				sum = sum + SUM_W'($signed(cfg.weights[WEIGHT_W*i +: WEIGHT_W]));
				cnt = cnt + CNT_W'(1);
			end
		end
		abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		found   = (cnt >= cfg.line_thr);
	end

	// Build the job; frames that need no quotient divide zero by one
	always_comb begin
		job.dividend = '0;
		job.divisor  = CNT_W'(1);
		job.neg      = 1'b0;
		job.status   = STATUS_DISABLED;
		job.dashed   = 1'b0;
		job.finish   = 1'b0;
		if (enable) begin
			job.dashed = dashed_next;
			job.finish = finish_next;
			job.status = found ? STATUS_FOUND : STATUS_LOST;
			if (found && cnt != '0) begin
				job.dividend = {abs_sum, 4'b0000};
				job.divisor  = cnt;
				job.neg      = sum[SUM_W-1];
			end
		end
	end

	// Advance detector state on each accepted transaction; a disabled one clears the gap detector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q    <= '0;
			dashed_q <= 1'b0;
			fin_q    <= '0;
		end else if (accept) begin
			if (enable) begin
				gap_q    <= gap_next;
				dashed_q <= dashed_next;
				fin_q    <= fin_next;
			end else begin
				gap_q    <= '0;
				dashed_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/lscm_queue.sv
// Two-entry job queue between the front end and the divider.
module lscm_queue
	import lscm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	output logic full,
	input  logic rd,
	output job_t rd_job,
	output logic avail
);

	job_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] level_q;

	assign full   = (level_q == 2'd2);
	assign avail  = (level_q != 2'd0);
	assign rd_job = entry_q[rd_ptr_q];

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (wr && !full) entry_q[wr_ptr_q] <= wr_job;
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (wr && !full) wr_ptr_q <= ~wr_ptr_q;
			if (rd && avail) rd_ptr_q <= ~rd_ptr_q;
			level_q <= level_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && avail) ? 1 : 0);
		end
	end

endmodule

>>> rtl/core/lscm_back.sv
// Back end: serial divider for the centroid and the result register.
module lscm_back
	import lscm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_avail,
	input  job_t                    job,
	output logic                    job_take,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [ERR_W-1:0] position_error,
	output logic [1:0]              track_status,
	output logic                    dashed_line,
	output logic                    finish_line
);

	back_state_t      state_q, state_next;
	logic             load_div, div_step, load_out;
	logic [CNT_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [CNT_W-1:0] div_q;
	logic [STEP_W-1:0] step_q;
	logic             neg_q;
	logic [1:0]       status_q;
	logic             dashed_q, finish_q;
	logic [CNT_W:0]   trial;
	logic             fits;
	logic [ERR_W-1:0] q12;
	logic             out_valid_q;

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			BK_IDLE: if (job_avail) state_next = BK_DIV;
			BK_DIV:  if (step_q == '0) state_next = BK_DONE;
			BK_DONE: if (!out_valid_q || pop) state_next = BK_IDLE;
			default: state_next = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		load_div = 1'b0;
		div_step = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: load_div = job_avail;
			BK_DIV:  div_step = 1'b1;
			BK_DONE: load_out = ~out_valid_q | pop;
			default: ;
		endcase
	end

	assign job_take = load_div;

	// One restoring step per cycle
	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign fits  = (trial >= {1'b0, div_q});
	assign q12   = quo_q[ERR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_next;
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (load_div) begin
			rem_q    <= '0;
			quo_q    <= job.dividend;
			div_q    <= job.divisor;
			step_q   <= STEP_W'(MAG_W - 1);
			neg_q    <= job.neg;
			status_q <= job.status;
			dashed_q <= job.dashed;
			finish_q <= job.finish;
		end else if (div_step) begin
			rem_q  <= fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			quo_q  <= {quo_q[MAG_W-2:0], fits};
			step_q <= step_q - STEP_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			position_error <= neg_q ? $signed(~q12 + ERR_W'(1)) : $signed(q12);
			track_status   <= status_q;
			dashed_line    <= dashed_q;
			finish_line    <= finish_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (pop) out_valid_q <= 1'b0;
	end

	assign empty = ~out_valid_q;

endmodule

>>> rtl/core/line_sensor_centroid_marks_top.sv
// Top level of the line sensor centroid and track marks block.
//
// Usage: write the four registers on the cfg port (weights, line threshold,
// dash gap threshold, dash hold) while the block is idle. Push one frame of
// eight sensor bits plus enable whenever full is low. Each frame yields one
// result (position error in signed Q8.4, track status, dashed and finish
// flags), shown while empty is low and taken with pop.
// The centroid is formed by the 15-step serial restoring divider, which sits
// between a load state and an output state. The divider works on one job at
// a time and takes a new job only after the previous result has been loaded.
// The front end updates the gap and finish detectors as a frame is taken and
// hands a job to a two-entry queue. While the receiver stalls, two queued
// jobs, one finished quotient held in the divider and one result can wait;
// full rises when the queue fills.
// Reset clears the detectors, the queue and the result valid flag and loads
// the register defaults (weights 0, thresholds 1, 5, hold 5).
module line_sensor_centroid_marks_top
	import lscm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [WEIGHTS_W-1:0]    cfg_data,
	input  logic                    push,
	output logic                    full,
	input  logic [SENSOR_COUNT-1:0] sensor_bits,
	input  logic                    enable,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [ERR_W-1:0] position_error,
	output logic [1:0]              track_status,
	output logic                    dashed_line,
	output logic                    finish_line
);

	cfg_t cfg_q;
	job_t front_job, queue_job;
	logic front_push, queue_avail, back_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weights   <= '0;
			cfg_q.line_thr  <= CNT_W'(1);
			cfg_q.dash_thr  <= 8'd5;
			cfg_q.dash_hold <= 8'd5;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WEIGHTS:   cfg_q.weights   <= cfg_data;
				REG_LINE_THR:  cfg_q.line_thr  <= cfg_data[CNT_W-1:0];
				REG_DASH_THR:  cfg_q.dash_thr  <= cfg_data[7:0];
				REG_DASH_HOLD: cfg_q.dash_hold <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lscm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.sensor_bits (sensor_bits),
		.enable      (enable),
		.queue_full  (full),
		.job_push    (front_push),
		.job         (front_job)
	);

	lscm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_push),
		.wr_job (front_job),
		.full   (full),
		.rd     (back_take),
		.rd_job (queue_job),
		.avail  (queue_avail)
	);

	lscm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_avail      (queue_avail),
		.job            (queue_job),
		.job_take       (back_take),
		.empty          (empty),
		.pop            (pop),
		.position_error (position_error),
		.track_status   (track_status),
		.dashed_line    (dashed_line),
		.finish_line    (finish_line)
	);

`ifndef SYNTHESIS
	// A disabled result carries no error and no flags
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && track_status == STATUS_DISABLED) |->
		(position_error == '0 && !dashed_line && !finish_line))
		else $error("disabled result with nonzero fields");

	// A lost line reports zero error
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && track_status == STATUS_LOST) |-> (position_error == '0))
		else $error("lost line with nonzero error");

	// A waiting result is not dropped without a pop
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result lost while stalled");

	// The divider only takes a job the queue holds
	assert property (@(posedge clk) disable iff (!arst_n)
		back_take |-> queue_avail)
		else $error("job taken from empty queue");
`endif

endmodule
